>>> rtl/mfr_pkg.sv
// Shared types and constants for the mono fold linear resampler.
package mfr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PHASE_W = 18;
    localparam int MAX_OUT = 7;
    localparam logic [PHASE_W-1:0] PHASE_ONE = 18'h10000;
    localparam logic [31:0] STEP_MIN = 32'd9363;
    localparam logic [31:0] STEP_MAX = 32'd196608;
    localparam logic [15:0] SRC_RATE_RESET = 16'd48000;

    typedef logic [PHASE_W-1:0] phase_t;

    typedef struct packed {
        logic   busy;
        phase_t step;
    } div_status_t;

    // Bound the raw quotient so a frame gives 0..7 results and the phase stays in 18 bits.
    function automatic phase_t clamp_step(input logic [31:0] q);
        phase_t r;
        if (q < STEP_MIN)
        begin
            r = PHASE_W'(STEP_MIN);
        end
        else if (q > STEP_MAX)
        begin
            r = PHASE_W'(STEP_MAX);
        end
        else
        begin
            r = q[PHASE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/mfr_step_div.sv
// Reciprocal-multiply unit that derives the phase step from the source rate.
module mfr_step_div #(
    parameter int OUTPUT_RATE = 48000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         rate,
    output mfr_pkg::div_status_t status
);
    import mfr_pkg::*;

    // rate * 2^16 / OUTPUT_RATE, floored, equals (rate * RECIP) >> RECIP_SHIFT
    // for every 16-bit rate, since rate * OUTPUT_RATE stays below 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = 33;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << (FRAC_BITS + RECIP_SHIFT)) + 64'(OUTPUT_RATE) - 64'd1) / 64'(OUTPUT_RATE);
    localparam logic [52:0] RECIP = RECIP_WIDE[52:0];
    localparam logic [47:0] RESET_DVD = {16'd0, SRC_RATE_RESET, 16'd0};
    localparam logic [47:0] RESET_Q = RESET_DVD / OUTPUT_RATE;
    localparam phase_t RESET_STEP = clamp_step(RESET_Q[31:0]);

    typedef enum logic [2:0] {
        DS_IDLE  = 3'b001,
        DS_MUL   = 3'b010,
        DS_CLAMP = 3'b100
    } div_state_t;

    div_state_t    div_state_reg;
    logic [15:0]   rate_reg;
    logic [52:0]   prod_reg;
    phase_t        step_reg;

    logic [52:0]   prod_next;

    always_comb
    begin
        prod_next = {37'd0, rate_reg} * RECIP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DS_IDLE;
            step_reg      <= RESET_STEP;
        end
        else if (start)
        begin
            div_state_reg <= DS_MUL;
        end
        else
        begin
            unique case (div_state_reg)
                DS_IDLE:
                begin
                    div_state_reg <= DS_IDLE;
                end
                DS_MUL:
                begin
                    div_state_reg <= DS_CLAMP;
                end
                DS_CLAMP:
                begin
                    step_reg      <= clamp_step({12'd0, prod_reg[52:RECIP_SHIFT]});
                    div_state_reg <= DS_IDLE;
                end
                default:
                begin
                    div_state_reg <= DS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rate_reg <= rate;
        end
        if (div_state_reg == DS_MUL)
        begin
            prod_reg <= prod_next;
        end
    end

    assign status.busy = (div_state_reg != DS_IDLE);
    assign status.step = step_reg;

endmodule

>>> rtl/mono_fold_linear_resampler.sv
// Top level: stereo-to-mono fold and linear-interpolation resampler.
// A frame is taken, checked the next cycle, then each result passes a multiply state and
// an emit state that waits for the output to be free; the result is registered on emit.
// The input stays not ready until a frame's last result is emitted, since the shared
// multiplier and its sequencer serve one frame at a time; a frame gives up to 7 results,
// and a priming or empty frame returns to idle after the check. A cfg_we write starts a
// reciprocal multiply for the phase step; the input is held not ready until it ends.
// Reset clears priming, phase and held sample, and loads the step for a 48000 Hz source.
module mono_fold_linear_resampler #(
    parameter int OUTPUT_RATE = 48000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic               stereo,
    input  logic               new_stream,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample,
    output logic               run_last,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);
    import mfr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t      state_reg;
    div_status_t div_status;

    // Frame context
    logic signed [15:0] mono_reg;
    logic               ns_reg;
    logic signed [15:0] held_reg;
    logic               primed_reg;
    phase_t             phase_reg;
    logic [2:0]         cnt_reg;

    // Shared multiplier result and the run-end flag it carries
    logic signed [33:0] prod_reg;
    logic               last_reg;

    // Output holding register
    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic               run_last_reg;

    logic signed [16:0] fold_sum;
    logic signed [15:0] fold_mono;
    logic signed [16:0] diff;
    logic signed [33:0] prod_next;
    phase_t             phase_next;
    logic               last_next;
    logic signed [17:0] interp_sum;
    logic               in_beat;
    logic               out_free;

    mfr_step_div #(
        .OUTPUT_RATE(OUTPUT_RATE)
    ) u_step_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we),
        .rate   (cfg_wdata),
        .status (div_status)
    );

    assign in_ready = (state_reg == ST_IDLE) && !div_status.busy;
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        // Fold to mono, truncating toward zero: bias negative sums up by one before halving
        fold_sum   = stereo ? (17'(left_sample) + 17'(right_sample))
                            : (17'(left_sample) + 17'(left_sample));
        fold_sum   = fold_sum + 17'(fold_sum[16]);
        fold_mono  = fold_sum[16:1];

        // held*(1-f) + mono*f == held*1.0 + (mono-held)*f
        diff       = 17'(mono_reg) - 17'(held_reg);
        prod_next  = 34'(diff) * $signed({18'd0, phase_reg[FRAC_BITS-1:0]});
        phase_next = phase_reg + div_status.step;
        last_next  = (phase_next >= PHASE_ONE) || (cnt_reg == 3'(MAX_OUT - 1));
        interp_sum = 18'(held_reg) + prod_reg[33:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            phase_reg     <= '0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the taken beat; in the emit state the arm below decides instead
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    cnt_reg <= '0;
                    if (ns_reg || !primed_reg)
                    begin
                        // Prime: hold the sample, start one frame ahead and drop to zero
                        held_reg   <= mono_reg;
                        primed_reg <= 1'b1;
                        phase_reg  <= '0;
                        state_reg  <= ST_IDLE;
                    end
                    else if (phase_reg >= PHASE_ONE)
                    begin
                        phase_reg <= phase_reg - PHASE_ONE;
                        held_reg  <= mono_reg;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    phase_reg <= phase_next;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (last_reg)
                        begin
                            // Advance to the next source frame
                            phase_reg <= phase_reg - PHASE_ONE;
                            held_reg  <= mono_reg;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 3'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mono_reg <= fold_mono;
            ns_reg   <= new_stream;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            last_reg <= last_next;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_sample_reg <= interp_sum[15:0];
            run_last_reg   <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_last   = run_last_reg;

endmodule
